// File: src/edlc_pkg.sv
package edlc_pkg;

    // default sizes for the top level parameters
    localparam int COUNT_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 32;

    // fixed field widths
    localparam int CMD_W      = 3;
    localparam int CNT_IN_W   = 16;
    localparam int OUT_POS_W  = 32;
    localparam int PHASE_W    = 2;
    localparam int DEC_W      = 3;
    localparam int STEP_W     = 16;
    localparam int TICK_W     = 8;
    localparam int THR_W      = 10;
    localparam int THR_SHIFT  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // accumulator and average arithmetic
    localparam int SUM_W     = 32;
    localparam int FRAC_BITS = 8;
    localparam int AVG_W     = SUM_W + FRAC_BITS;
    localparam int TOTAL_W   = AVG_W + 1;
    localparam int PROD_W    = TOTAL_W + THR_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NOP    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HOME   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RECAL  = 3'd4;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_DITHER_L  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_DITHER_R  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_OFFLINE_L = 2'd2;
    localparam logic [PHASE_W-1:0] PH_OFFLINE_R = 2'd3;

    // decision codes
    localparam logic [DEC_W-1:0] DEC_NONE   = 3'd0;
    localparam logic [DEC_W-1:0] DEC_PLUS   = 3'd1;
    localparam logic [DEC_W-1:0] DEC_MINUS  = 3'd2;
    localparam logic [DEC_W-1:0] DEC_STAYED = 3'd3;
    localparam logic [DEC_W-1:0] DEC_SKIP   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_OFS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DL_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DR_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd7;

    // register reset values
    localparam logic signed [OUT_POS_W-1:0] INIT_POS_RST = 32'sd500;
    localparam logic [STEP_W-1:0] OFFLINE_OFS_RST = 16'd64;
    localparam logic [STEP_W-1:0] DITHER_STEP_RST = 16'd16;
    localparam logic [TICK_W-1:0] DL_TICKS_RST    = 8'd2;
    localparam logic [TICK_W-1:0] DR_TICKS_RST    = 8'd3;
    localparam logic [TICK_W-1:0] OFF_TICKS_RST   = 8'd25;
    localparam logic [TICK_W-1:0] ON_TICKS_RST    = 8'd25;
    localparam logic [THR_W-1:0]  THRESHOLD_RST   = 10'd102;

    // far position used by the home command
    localparam logic [OUT_POS_W-1:0] HOME_TARGET = 32'd1000000;

endpackage

// File: src/etalon_dither_lock_controller_top.sv
// channel  | signals                              | direction | moves
// ---------+--------------------------------------+-----------+------------------------------
// in       | in_valid, in_ready, cmd, ref_counts  | into      | one tick request
// out      | out_valid, out_ready, result fields  | out of    | one result per tick request
// cfg      | cfg_valid, cfg_ready, cfg_index/data | into      | register write
//
// a plain tick request goes from idle straight to the output state, which registers the result
// a toggle ending an offline phase first runs the divide, sum, multiply and decide states: the
// shared restoring divider yields one quotient bit per cycle for the left then the right average
// in_ready is high only while the sequencer is idle; a result waiting on out_ready holds
// the sequencer, cfg_ready is always high
// rst_n clears state asynchronously and loads the register reset values
module etalon_dither_lock_controller_top
    import edlc_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [CMD_W-1:0]             cmd,
    input  logic [CNT_IN_W-1:0]          ref_counts,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         move_valid,
    output logic signed [OUT_POS_W-1:0]  move_target,
    output logic [PHASE_W-1:0]           phase,
    output logic signed [OUT_POS_W-1:0]  online_now,
    output logic [DEC_W-1:0]             decision,
    output logic                         unknown_cmd,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [COUNT_BITS-1:0]    cnt_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_L,
        S_DIV_R,
        S_SUM,
        S_MUL,
        S_DECIDE,
        S_OUT
    } state_t;

    // low 32 bits of a position, zero filled for narrow positions
    function automatic logic [OUT_POS_W-1:0] pos_low(input pos_t p);
        logic [63:0] w;
        w = 64'(p);
        return w[OUT_POS_W-1:0];
    endfunction

    // configuration registers
    logic signed [OUT_POS_W-1:0] init_pos_reg;
    logic [STEP_W-1:0]           offline_ofs_reg;
    logic [STEP_W-1:0]           dither_step_reg;
    logic [TICK_W-1:0]           dl_ticks_reg;
    logic [TICK_W-1:0]           dr_ticks_reg;
    logic [TICK_W-1:0]           off_ticks_reg;
    logic [TICK_W-1:0]           on_ticks_reg;
    logic [THR_W-1:0]            threshold_reg;

    // controller state
    state_t                state_reg, state_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [TICK_W-1:0]     dither_timer_reg, dither_timer_next;
    logic [TICK_W-1:0]     online_timer_reg, online_timer_next;
    logic [TICK_W-1:0]     offline_timer_reg, offline_timer_next;
    logic                  parity_reg, parity_next;
    logic                  homing_reg, homing_next;
    logic [SUM_W-1:0]      left_sum_reg, left_sum_next;
    logic [SUM_W-1:0]      right_sum_reg, right_sum_next;
    cnt_t                  left_n_reg, left_n_next;
    cnt_t                  right_n_reg, right_n_next;
    pos_t                  online_pos_reg, online_pos_next;
    logic                  side_left_reg, side_left_next;

    // decision datapath
    logic [AVG_W-1:0]      avg_l_reg, avg_l_next;
    logic [AVG_W-1:0]      avg_r_reg, avg_r_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;

    // pending result
    logic                  res_valid_reg, res_valid_next;
    logic [OUT_POS_W-1:0]  res_target_reg, res_target_next;
    logic [DEC_W-1:0]      res_dec_reg, res_dec_next;
    logic                  res_unknown_reg, res_unknown_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_move_valid_reg, out_move_valid_next;
    logic [OUT_POS_W-1:0]  out_target_reg, out_target_next;
    logic [PHASE_W-1:0]    out_phase_reg, out_phase_next;
    logic [OUT_POS_W-1:0]  out_online_reg, out_online_next;
    logic [DEC_W-1:0]      out_dec_reg, out_dec_next;
    logic                  out_unknown_reg, out_unknown_next;

    // divider hookup
    logic                  div_start;
    logic [AVG_W-1:0]      div_num;
    cnt_t                  div_den;
    logic                  div_busy;
    logic                  div_done;
    logic [AVG_W-1:0]      div_quo;

    // shared helper values
    logic [SUM_W:0]        left_add, right_add;
    logic [SUM_W-1:0]      left_sat, right_sat;
    cnt_t                  left_inc, right_inc;
    pos_t                  pos_plus_step, pos_minus_step;
    pos_t                  pos_plus_ofs, pos_minus_ofs;
    logic [PROD_W-1:0]     lhs_left, lhs_right;
    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // saturating accumulators
    assign left_add  = {1'b0, left_sum_reg} + (SUM_W+1)'(ref_counts);
    assign right_add = {1'b0, right_sum_reg} + (SUM_W+1)'(ref_counts);
    assign left_sat  = left_add[SUM_W] ? '1 : left_add[SUM_W-1:0];
    assign right_sat = right_add[SUM_W] ? '1 : right_add[SUM_W-1:0];
    assign left_inc  = (left_n_reg == '1) ? left_n_reg : left_n_reg + 1'b1;
    assign right_inc = (right_n_reg == '1) ? right_n_reg : right_n_reg + 1'b1;

    // position arithmetic wraps at the position width
    assign pos_plus_step  = online_pos_reg + POSITION_BITS'(dither_step_reg);
    assign pos_minus_step = online_pos_reg - POSITION_BITS'(dither_step_reg);
    assign pos_plus_ofs   = online_pos_reg + POSITION_BITS'(offline_ofs_reg);
    assign pos_minus_ofs  = online_pos_reg - POSITION_BITS'(offline_ofs_reg);

    // scaled balance differences against threshold times total
    assign lhs_left  = PROD_W'({avg_l_reg - avg_r_reg, {THR_SHIFT{1'b0}}});
    assign lhs_right = PROD_W'({avg_r_reg - avg_l_reg, {THR_SHIFT{1'b0}}});

    // divider operands: left side from idle, right side afterwards
    assign div_num = (state_reg == S_IDLE) ? {left_sum_reg, {FRAC_BITS{1'b0}}}
                                           : {right_sum_reg, {FRAC_BITS{1'b0}}};
    assign div_den = (state_reg == S_IDLE) ? left_n_reg : right_n_reg;

    edlc_div #(
        .NUM_W (AVG_W),
        .DEN_W (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // sequencer next state
    always_comb
    begin
        logic is_left;
        logic dtx;
        logic otx;

        is_left = 1'b0;
        dtx     = 1'b0;
        otx     = 1'b0;

        state_next         = state_reg;
        phase_next         = phase_reg;
        dither_timer_next  = dither_timer_reg;
        online_timer_next  = online_timer_reg;
        offline_timer_next = offline_timer_reg;
        parity_next        = parity_reg;
        homing_next        = homing_reg;
        left_sum_next      = left_sum_reg;
        right_sum_next     = right_sum_reg;
        left_n_next        = left_n_reg;
        right_n_next       = right_n_reg;
        online_pos_next    = online_pos_reg;
        side_left_next     = side_left_reg;
        avg_l_next         = avg_l_reg;
        avg_r_next         = avg_r_reg;
        total_next         = total_reg;
        prod_next          = prod_reg;
        res_valid_next     = res_valid_reg;
        res_target_next    = res_target_reg;
        res_dec_next       = res_dec_reg;
        res_unknown_next   = res_unknown_reg;
        div_start          = 1'b0;

        out_valid_next      = out_valid_reg && !out_ready;
        out_move_valid_next = out_move_valid_reg;
        out_target_next     = out_target_reg;
        out_phase_next      = out_phase_reg;
        out_online_next     = out_online_reg;
        out_dec_next        = out_dec_reg;
        out_unknown_next    = out_unknown_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_valid_next   = 1'b0;
                    res_target_next  = '0;
                    res_dec_next     = DEC_NONE;
                    res_unknown_next = 1'b0;
                    state_next       = S_OUT;

                    if (cmd == CMD_TOGGLE)
                    begin
                        res_valid_next = 1'b1;
                        unique case (phase_reg)
                            PH_DITHER_L, PH_DITHER_R:
                            begin
                                is_left = (phase_reg == PH_DITHER_L);
                                if (is_left)
                                begin
                                    res_target_next = pos_low(pos_plus_step);
                                    left_sum_next   = left_sat;
                                    left_n_next     = left_inc;
                                end
                                else
                                begin
                                    res_target_next = pos_low(online_pos_reg);
                                    right_sum_next  = right_sat;
                                    right_n_next    = right_inc;
                                end
                                dtx = (dither_timer_reg == '0);
                                otx = (online_timer_reg == '0);
                                if (!dtx)
                                    dither_timer_next = dither_timer_reg - 1'b1;
                                if (!otx)
                                    online_timer_next = online_timer_reg - 1'b1;
                                if (dtx)
                                begin
                                    phase_next        = is_left ? PH_DITHER_R : PH_DITHER_L;
                                    dither_timer_next = is_left ? dr_ticks_reg : dl_ticks_reg;
                                end
                                // online period over: alternate offline side
                                if (otx)
                                begin
                                    parity_next        = !parity_reg;
                                    offline_timer_next = off_ticks_reg;
                                    phase_next = !parity_reg ? PH_OFFLINE_L : PH_OFFLINE_R;
                                end
                            end
                            PH_OFFLINE_L, PH_OFFLINE_R:
                            begin
                                is_left = (phase_reg == PH_OFFLINE_L);
                                res_target_next = is_left ? pos_low(pos_plus_ofs)
                                                          : pos_low(pos_minus_ofs);
                                if (offline_timer_reg == '0)
                                begin
                                    online_timer_next = on_ticks_reg;
                                    phase_next        = is_left ? PH_DITHER_L : PH_DITHER_R;
                                    dither_timer_next = is_left ? dl_ticks_reg : dr_ticks_reg;
                                    side_left_next    = is_left;
                                    div_start         = 1'b1;
                                    state_next        = S_DIV_L;
                                end
                                else
                                begin
                                    offline_timer_next = offline_timer_reg - 1'b1;
                                end
                            end
                            default:
                            begin
                                state_next = S_OUT;
                            end
                        endcase
                    end
                    else if (cmd == CMD_HOME)
                    begin
                        if (!homing_reg)
                        begin
                            homing_next     = 1'b1;
                            res_valid_next  = 1'b1;
                            res_target_next = HOME_TARGET;
                        end
                    end
                    else if (cmd > CMD_RECAL)
                    begin
                        res_unknown_next = 1'b1;
                    end
                end
            end
            S_DIV_L:
            begin
                if (div_done)
                begin
                    avg_l_next = (left_n_reg == '0) ? '0 : div_quo;
                    div_start  = 1'b1;
                    state_next = S_DIV_R;
                end
            end
            S_DIV_R:
            begin
                if (div_done)
                begin
                    avg_r_next = (right_n_reg == '0) ? '0 : div_quo;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                total_next = {1'b0, avg_l_reg} + {1'b0, avg_r_reg};
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(threshold_reg) * PROD_W'(total_reg);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (total_reg == '0)
                begin
                    res_dec_next = DEC_SKIP;
                end
                else if (avg_l_reg > avg_r_reg && lhs_left > prod_reg)
                begin
                    res_dec_next    = DEC_PLUS;
                    online_pos_next = pos_plus_step;
                end
                else if (avg_r_reg > avg_l_reg && lhs_right > prod_reg)
                begin
                    res_dec_next    = DEC_MINUS;
                    online_pos_next = pos_minus_step;
                end
                else
                begin
                    res_dec_next = DEC_STAYED;
                end
                // clear the side just left offline
                if (side_left_reg)
                begin
                    left_sum_next = '0;
                    left_n_next   = '0;
                end
                else
                begin
                    right_sum_next = '0;
                    right_n_next   = '0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    out_move_valid_next = res_valid_reg;
                    out_target_next     = res_target_reg;
                    out_phase_next      = phase_reg;
                    out_online_next     = pos_low(online_pos_reg);
                    out_dec_next        = res_dec_reg;
                    out_unknown_next    = res_unknown_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // writing the initial position also reloads the online position
        if (cfg_write && cfg_index == REG_INIT_POS)
            online_pos_next = POSITION_BITS'(signed'(cfg_data));
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            phase_reg         <= PH_OFFLINE_L;
            dither_timer_reg  <= '0;
            online_timer_reg  <= '0;
            offline_timer_reg <= OFF_TICKS_RST;
            parity_reg        <= 1'b0;
            homing_reg        <= 1'b0;
            left_sum_reg      <= '0;
            right_sum_reg     <= '0;
            left_n_reg        <= '0;
            right_n_reg       <= '0;
            online_pos_reg    <= POSITION_BITS'(INIT_POS_RST);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            dither_timer_reg  <= dither_timer_next;
            online_timer_reg  <= online_timer_next;
            offline_timer_reg <= offline_timer_next;
            parity_reg        <= parity_next;
            homing_reg        <= homing_next;
            left_sum_reg      <= left_sum_next;
            right_sum_reg     <= right_sum_next;
            left_n_reg        <= left_n_next;
            right_n_reg       <= right_n_next;
            online_pos_reg    <= online_pos_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        side_left_reg      <= side_left_next;
        avg_l_reg          <= avg_l_next;
        avg_r_reg          <= avg_r_next;
        total_reg          <= total_next;
        prod_reg           <= prod_next;
        res_valid_reg      <= res_valid_next;
        res_target_reg     <= res_target_next;
        res_dec_reg        <= res_dec_next;
        res_unknown_reg    <= res_unknown_next;
        out_move_valid_reg <= out_move_valid_next;
        out_target_reg     <= out_target_next;
        out_phase_reg      <= out_phase_next;
        out_online_reg     <= out_online_next;
        out_dec_reg        <= out_dec_next;
        out_unknown_reg    <= out_unknown_next;
    end

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_pos_reg    <= INIT_POS_RST;
            offline_ofs_reg <= OFFLINE_OFS_RST;
            dither_step_reg <= DITHER_STEP_RST;
            dl_ticks_reg    <= DL_TICKS_RST;
            dr_ticks_reg    <= DR_TICKS_RST;
            off_ticks_reg   <= OFF_TICKS_RST;
            on_ticks_reg    <= ON_TICKS_RST;
            threshold_reg   <= THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INIT_POS:    init_pos_reg    <= signed'(cfg_data);
                REG_OFFLINE_OFS: offline_ofs_reg <= cfg_data[STEP_W-1:0];
                REG_DITHER_STEP: dither_step_reg <= cfg_data[STEP_W-1:0];
                REG_DL_TICKS:    dl_ticks_reg    <= cfg_data[TICK_W-1:0];
                REG_DR_TICKS:    dr_ticks_reg    <= cfg_data[TICK_W-1:0];
                REG_OFF_TICKS:   off_ticks_reg   <= cfg_data[TICK_W-1:0];
                REG_ON_TICKS:    on_ticks_reg    <= cfg_data[TICK_W-1:0];
                REG_THRESHOLD:   threshold_reg   <= cfg_data[THR_W-1:0];
                default:         init_pos_reg    <= init_pos_reg;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign move_valid  = out_move_valid_reg;
    assign move_target = signed'(out_target_reg);
    assign phase       = out_phase_reg;
    assign online_now  = signed'(out_online_reg);
    assign decision    = out_dec_reg;
    assign unknown_cmd = out_unknown_reg;

    // divider is only started when idle
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // online position moves only on a decision or an initial position write
    a_pos_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!(cfg_write && cfg_index == REG_INIT_POS) && state_reg != S_DECIDE)
        |=> $stable(online_pos_reg))
        else $error("online position changed outside a decision");

    // an empty left accumulator has no sum
    a_left_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (left_n_reg == '0) |-> (left_sum_reg == '0))
        else $error("left sum without samples");

    // a pending result is held until the output register frees up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result left before output register was free");

    // a decision is only reported together with a move
    a_dec_move: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dec_reg != DEC_NONE) |-> out_move_valid_reg)
        else $error("decision reported without a move");

endmodule

// File: src/edlc_div.sv
module edlc_div
    import edlc_pkg::*;
#(
    parameter int NUM_W = AVG_W,
    parameter int DEN_W = COUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
